@@ sv/pc_pkg.sv @@
// ----------------------------------------------------------------------------
// pc_pkg: shared types and constants for the pixel compositor
// Holds the operation codes, register indexes, the configuration bundle and
// the pixel and result types used across the compositor modules.
// ----------------------------------------------------------------------------
package pc_pkg;

  // Channel and register field widths.
  localparam int unsigned ChanWidth  = 8;
  localparam int unsigned ShiftWidth = 9;
  localparam int unsigned IndexWidth = 3;
  localparam int unsigned DataWidth  = 9;

  // Levels used by the operations.
  localparam logic [ChanWidth-1:0] FullLevel = 8'd255;
  localparam logic [ChanWidth-1:0] BrightMin = 8'd200;

  // Raster operation codes held in the mode register.
  typedef enum logic [1:0] {
    OP_FILL  = 2'd0,
    OP_BLEND = 2'd1,
    OP_KEY   = 2'd2,
    OP_SHIFT = 2'd3
  } op_mode_t;

  // Configuration register indexes.
  typedef enum logic [IndexWidth-1:0] {
    REG_OP_MODE      = 3'd0,
    REG_PAINT_RED    = 3'd1,
    REG_PAINT_GREEN  = 3'd2,
    REG_PAINT_BLUE   = 3'd3,
    REG_PAINT_ALPHA  = 3'd4,
    REG_SHIFT_AMOUNT = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [ChanWidth-1:0] red;
    logic [ChanWidth-1:0] green;
    logic [ChanWidth-1:0] blue;
  } pixel_t;

  // Register contents seen by the datapath.
  typedef struct packed {
    op_mode_t                       mode;
    pixel_t                         paint;
    logic [ChanWidth-1:0]           alpha;
    logic signed [ShiftWidth-1:0]   shift;
  } cfg_t;

  typedef struct packed {
    pixel_t pix;
    logic   written;
  } result_t;

endpackage

@@ sv/pixel_compositor.sv @@
// ----------------------------------------------------------------------------
// pixel_compositor: per-pixel raster operation unit
// The start transfer passes through the input register and then the result
// register, which raises done together with the result.
// Throughput: one pixel per cycle, set by the input and result registers.
// busy is never asserted and results cannot be stalled by the receiver.
// Reset clears the pipeline valid flags and returns the configuration registers to defaults.
// ----------------------------------------------------------------------------
module pixel_compositor (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [pc_pkg::ChanWidth-1:0]    dst_red,
  input  logic [pc_pkg::ChanWidth-1:0]    dst_green,
  input  logic [pc_pkg::ChanWidth-1:0]    dst_blue,
  input  logic [pc_pkg::ChanWidth-1:0]    src_red,
  input  logic [pc_pkg::ChanWidth-1:0]    src_green,
  input  logic [pc_pkg::ChanWidth-1:0]    src_blue,
  output logic                            done,
  output logic [pc_pkg::ChanWidth-1:0]    out_red,
  output logic [pc_pkg::ChanWidth-1:0]    out_green,
  output logic [pc_pkg::ChanWidth-1:0]    out_blue,
  output logic                            written,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pc_pkg::IndexWidth-1:0]   cfg_index,
  input  logic [pc_pkg::DataWidth-1:0]    cfg_data
);

  pc_pkg::cfg_t    cfg;
  pc_pkg::pixel_t  dst_q;
  pc_pkg::pixel_t  src_q;
  logic            in_valid;
  pc_pkg::result_t res_next;
  pc_pkg::result_t res;

  // The unit takes a pixel and a register transfer in every cycle.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  pc_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    dst_q <= '{red: dst_red, green: dst_green, blue: dst_blue};
    src_q <= '{red: src_red, green: src_green, blue: src_blue};
  end

  pc_raster_op u_raster_op (
    .cfg (cfg),
    .dst (dst_q),
    .src (src_q),
    .res (res_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  assign out_red   = res.pix.red;
  assign out_green = res.pix.green;
  assign out_blue  = res.pix.blue;
  assign written   = res.written;

`ifndef SYNTHESIS
  // Every result strobe stems from an earlier start transfer.
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result strobe without a matching start transfer");

  // Every start transfer yields a later result strobe.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("start transfer lost in the pipeline");

  // An unwritten pixel leaves with its destination value unchanged.
  assert property (@(posedge clk) disable iff (rst)
    (done && !written) |-> (out_red == $past(dst_red, 2) && out_green == $past(dst_green, 2)
                            && out_blue == $past(dst_blue, 2)))
    else $error("unwritten pixel differs from its destination");

  // Fill mode always writes the pixel.
  assert property (@(posedge clk) disable iff (rst)
    (done && cfg.mode == pc_pkg::OP_FILL) |-> written)
    else $error("fill mode result not flagged as written");
`endif

endmodule

@@ sv/pc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// pc_cfg_regs: configuration register file
// Takes register writes from the configuration channel and presents the
// current settings to the datapath as one bundle.
// ----------------------------------------------------------------------------
module pc_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [pc_pkg::IndexWidth-1:0]       wr_index,
  input  logic [pc_pkg::DataWidth-1:0]        wr_data,
  output pc_pkg::cfg_t                        cfg
);

  // A write to an index beyond the register list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode  <= pc_pkg::OP_FILL;
      cfg.paint <= '0;
      cfg.alpha <= pc_pkg::FullLevel;
      cfg.shift <= '0;
    end else if (wr_en) begin
      case (wr_index)
        pc_pkg::REG_OP_MODE:      cfg.mode        <= pc_pkg::op_mode_t'(wr_data[1:0]);
        pc_pkg::REG_PAINT_RED:    cfg.paint.red   <= wr_data[pc_pkg::ChanWidth-1:0];
        pc_pkg::REG_PAINT_GREEN:  cfg.paint.green <= wr_data[pc_pkg::ChanWidth-1:0];
        pc_pkg::REG_PAINT_BLUE:   cfg.paint.blue  <= wr_data[pc_pkg::ChanWidth-1:0];
        pc_pkg::REG_PAINT_ALPHA:  cfg.alpha       <= wr_data[pc_pkg::ChanWidth-1:0];
        pc_pkg::REG_SHIFT_AMOUNT: cfg.shift       <= wr_data[pc_pkg::ShiftWidth-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ sv/pc_blend_channel.sv @@
// ----------------------------------------------------------------------------
// pc_blend_channel: one colour channel of the alpha blend
// Computes (d*(255-a) + c*a) / 255, truncated, without a divider.
// ----------------------------------------------------------------------------
module pc_blend_channel (
  input  logic [pc_pkg::ChanWidth-1:0] dst,
  input  logic [pc_pkg::ChanWidth-1:0] paint,
  input  logic [pc_pkg::ChanWidth-1:0] alpha,
  output logic [pc_pkg::ChanWidth-1:0] mixed
);

  logic [pc_pkg::ChanWidth-1:0]   alpha_inv;
  logic [2*pc_pkg::ChanWidth-1:0] dst_term;
  logic [2*pc_pkg::ChanWidth-1:0] paint_term;
  logic [2*pc_pkg::ChanWidth-1:0] numer;
  logic [2*pc_pkg::ChanWidth:0]   scaled;

  // Weighted sum; 255 - a is the bitwise complement of an 8-bit alpha.
  // The sum never exceeds 255*255, so it fits in 16 bits.
  assign alpha_inv  = ~alpha;
  assign dst_term   = (2*pc_pkg::ChanWidth)'(dst)   * (2*pc_pkg::ChanWidth)'(alpha_inv);
  assign paint_term = (2*pc_pkg::ChanWidth)'(paint) * (2*pc_pkg::ChanWidth)'(alpha);
  assign numer      = dst_term + paint_term;

  // Exact floor division by 255 for any numerator up to 255*255:
  // q = (n + (n >> 8) + 1) >> 8.
  assign scaled = (2*pc_pkg::ChanWidth+1)'(numer)
                + (2*pc_pkg::ChanWidth+1)'(numer[2*pc_pkg::ChanWidth-1:pc_pkg::ChanWidth])
                + (2*pc_pkg::ChanWidth+1)'(1);
  assign mixed  = scaled[2*pc_pkg::ChanWidth-1:pc_pkg::ChanWidth];

endmodule

@@ sv/pc_raster_op.sv @@
// ----------------------------------------------------------------------------
// pc_raster_op: raster operation datapath
// Selects fill, alpha blend, white colour-key copy or bright shift for one
// pixel and flags whether the destination is written.
// ----------------------------------------------------------------------------
module pc_raster_op (
  input  pc_pkg::cfg_t    cfg,
  input  pc_pkg::pixel_t  dst,
  input  pc_pkg::pixel_t  src,
  output pc_pkg::result_t res
);

  pc_pkg::pixel_t               mixed;
  logic [pc_pkg::ChanWidth-1:0] shift_low;
  logic                         src_white;
  logic                         dst_bright;

  // Per-channel blend units.
  pc_blend_channel u_blend_red (
    .dst   (dst.red),
    .paint (cfg.paint.red),
    .alpha (cfg.alpha),
    .mixed (mixed.red)
  );

  pc_blend_channel u_blend_green (
    .dst   (dst.green),
    .paint (cfg.paint.green),
    .alpha (cfg.alpha),
    .mixed (mixed.green)
  );

  pc_blend_channel u_blend_blue (
    .dst   (dst.blue),
    .paint (cfg.paint.blue),
    .alpha (cfg.alpha),
    .mixed (mixed.blue)
  );

  // Bit 8 of the shift is worth 256 and vanishes modulo 256.
  assign shift_low  = cfg.shift[pc_pkg::ChanWidth-1:0];
  assign src_white  = (src.red == pc_pkg::FullLevel) && (src.green == pc_pkg::FullLevel)
                   && (src.blue == pc_pkg::FullLevel);
  assign dst_bright = (dst.red > pc_pkg::BrightMin) && (dst.green > pc_pkg::BrightMin)
                   && (dst.blue > pc_pkg::BrightMin);

  // Operation select; the destination passes through unless a write occurs.
  always_comb begin
    res.pix     = dst;
    res.written = 1'b0;
    case (cfg.mode)
      pc_pkg::OP_FILL: begin
        res.pix     = cfg.paint;
        res.written = 1'b1;
      end
      pc_pkg::OP_BLEND: begin
        if (cfg.alpha == pc_pkg::FullLevel) begin
          res.pix     = cfg.paint;
          res.written = 1'b1;
        end else if (cfg.alpha != '0) begin
          res.pix     = mixed;
          res.written = 1'b1;
        end
      end
      pc_pkg::OP_KEY: begin
        if (!src_white) begin
          res.pix     = src;
          res.written = 1'b1;
        end
      end
      pc_pkg::OP_SHIFT: begin
        if (dst_bright) begin
          res.pix.red   = dst.red + shift_low;
          res.pix.green = dst.green + shift_low;
          res.pix.blue  = dst.blue + shift_low;
          res.written   = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ tb/pixel_compositor_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pixel_compositor_tb: self-checking testbench for the pixel compositor
// A driver feeds pixel pairs from a queue with random gaps or none, and a monitor
// predicts each result from its own copy of the registers and checks every
// result strobe against the oldest prediction. A directed part covers each
// operation and its corner cases. Random phases with fresh register settings
// follow.
// ----------------------------------------------------------------------------
module pixel_compositor_tb;
  import pc_pkg::*;

  // One queued input transfer: destination and source pixels.
  typedef struct packed {
    pixel_t dst;
    pixel_t src;
  } pixel_job_t;

  // Register indexes outside the map; writes to them must be ignored.
  localparam logic [IndexWidth-1:0] RegUnusedLo = 3'd6;
  localparam logic [IndexWidth-1:0] RegUnusedHi = 3'd7;

  // Shift patterns of interest: -256, -255, +255 and a plain positive step.
  localparam logic [DataWidth-1:0] ShiftMinus256 = 9'h100;
  localparam logic [DataWidth-1:0] ShiftMinus255 = 9'h101;
  localparam logic [DataWidth-1:0] ShiftPlus255  = 9'h0FF;
  localparam logic [DataWidth-1:0] ShiftPlus55   = 9'd55;

  localparam pixel_t WhitePixel = {FullLevel, FullLevel, FullLevel};
  localparam cfg_t   RegsAtReset = '{mode: OP_FILL, paint: '0, alpha: FullLevel, shift: '0};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [ChanWidth-1:0]  dst_red = '0;
  logic [ChanWidth-1:0]  dst_green = '0;
  logic [ChanWidth-1:0]  dst_blue = '0;
  logic [ChanWidth-1:0]  src_red = '0;
  logic [ChanWidth-1:0]  src_green = '0;
  logic [ChanWidth-1:0]  src_blue = '0;
  logic                  done;
  logic [ChanWidth-1:0]  out_red;
  logic [ChanWidth-1:0]  out_green;
  logic [ChanWidth-1:0]  out_blue;
  logic                  written;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [IndexWidth-1:0] cfg_index = '0;
  logic [DataWidth-1:0]  cfg_data = '0;

  pixel_job_t pixel_jobs[$];
  result_t    expected_pixels[$];
  cfg_t       compositor_regs = RegsAtReset;
  pixel_job_t next_job;
  result_t    seen_result;
  result_t    wanted_result;
  logic       start_taken = 1'b0;
  logic       cfg_taken = 1'b0;
  logic       no_idle_run = 1'b0;
  int         gap_left = 0;
  int         jobs_queued = 0;
  int         results_done = 0;
  int         error_count = 0;
  int         random_jobs = 0;
  int         phase_len;
  op_mode_t   phase_mode;
  pixel_t     rand_dst;
  pixel_t     rand_src;

  pixel_compositor i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .dst_red   (dst_red),
    .dst_green (dst_green),
    .dst_blue  (dst_blue),
    .src_red   (src_red),
    .src_green (src_green),
    .src_blue  (src_blue),
    .done      (done),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .written   (written),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock generation.
  initial begin
    forever #10 clk = ~clk;
  end

  // Run time limit.
  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

  // Weighted blend of one channel, quotient truncated.
  function automatic logic [ChanWidth-1:0] blend_channel(logic [ChanWidth-1:0] d,
                                                         logic [ChanWidth-1:0] c,
                                                         logic [ChanWidth-1:0] a);
    int mix;
    mix = (int'(d) * (int'(FullLevel) - int'(a)) + int'(c) * int'(a)) / int'(FullLevel);
    return mix[ChanWidth-1:0];
  endfunction

  // Predicted result of one pixel pair under the given register settings.
  function automatic result_t composite_pixel(cfg_t regs, pixel_t d, pixel_t s);
    result_t              r;
    logic [ChanWidth-1:0] step;
    r.pix = d;
    r.written = 1'b0;
    step = regs.shift[ChanWidth-1:0];
    case (regs.mode)
      OP_FILL: begin
        r.pix = regs.paint;
        r.written = 1'b1;
      end
      OP_BLEND: begin
        if (regs.alpha == FullLevel) begin
          r.pix = regs.paint;
          r.written = 1'b1;
        end else if (regs.alpha != '0) begin
          r.pix.red   = blend_channel(d.red, regs.paint.red, regs.alpha);
          r.pix.green = blend_channel(d.green, regs.paint.green, regs.alpha);
          r.pix.blue  = blend_channel(d.blue, regs.paint.blue, regs.alpha);
          r.written = 1'b1;
        end
      end
      OP_KEY: begin
        if (s != WhitePixel) begin
          r.pix = s;
          r.written = 1'b1;
        end
      end
      default: begin
        // Bit 8 of the shift is worth 256 and vanishes modulo 256.
        if (d.red > BrightMin && d.green > BrightMin && d.blue > BrightMin) begin
          r.pix.red   = d.red + step;
          r.pix.green = d.green + step;
          r.pix.blue  = d.blue + step;
          r.written = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  // Channel value with the extremes drawn more often than by chance.
  function automatic logic [ChanWidth-1:0] rand_channel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return FullLevel;
      default: return ChanWidth'($urandom());
    endcase
  endfunction

  // Channel value that is mostly above the bright threshold.
  function automatic logic [ChanWidth-1:0] bright_channel();
    case ($urandom_range(0, 11))
      0: return BrightMin;
      1: return rand_channel();
      default: return ChanWidth'($urandom_range(int'(BrightMin) + 1, int'(FullLevel)));
    endcase
  endfunction

  // One register write transfer, driven at the falling edge.
  task automatic write_register(input logic [IndexWidth-1:0] idx,
                                input logic [DataWidth-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_pixel(input pixel_t dst, input pixel_t src);
    pixel_jobs.push_back('{dst: dst, src: src});
    jobs_queued++;
  endtask

  // Holds the sender back until every queued pixel has produced its result.
  task automatic wait_drained();
    do @(negedge clk); while (results_done < jobs_queued);
    repeat (4) @(negedge clk);
  endtask

  // Driver: presents queued pixels, holding each one until its transfer.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !start_taken) begin
      // Transfer still pending; keep the item on the ports.
    end else if (gap_left != 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pixel_jobs.size() != 0) begin
      next_job = pixel_jobs.pop_front();
      dst_red   <= next_job.dst.red;
      dst_green <= next_job.dst.green;
      dst_blue  <= next_job.dst.blue;
      src_red   <= next_job.src.red;
      src_green <= next_job.src.green;
      src_blue  <= next_job.src.blue;
      start <= 1'b1;
      gap_left <= no_idle_run ? 0 : $urandom_range(0, 17);
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: tracks register writes, predicts on each input transfer and
  // checks each result strobe against the oldest prediction.
  always @(posedge clk) begin
    start_taken <= !rst && start && !busy;
    cfg_taken   <= !rst && cfg_valid && cfg_ready;
    if (rst) begin
      compositor_regs = RegsAtReset;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_OP_MODE:      compositor_regs.mode = op_mode_t'(cfg_data[1:0]);
          REG_PAINT_RED:    compositor_regs.paint.red = cfg_data[ChanWidth-1:0];
          REG_PAINT_GREEN:  compositor_regs.paint.green = cfg_data[ChanWidth-1:0];
          REG_PAINT_BLUE:   compositor_regs.paint.blue = cfg_data[ChanWidth-1:0];
          REG_PAINT_ALPHA:  compositor_regs.alpha = cfg_data[ChanWidth-1:0];
          REG_SHIFT_AMOUNT: compositor_regs.shift = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        expected_pixels.push_back(composite_pixel(compositor_regs,
                                                  {dst_red, dst_green, dst_blue},
                                                  {src_red, src_green, src_blue}));
      end
      if (done) begin
        results_done++;
        seen_result = '{pix: '{out_red, out_green, out_blue}, written: written};
        if (expected_pixels.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: unexpected result r=%0d g=%0d b=%0d written=%0d", $realtime,
                     out_red, out_green, out_blue, written);
        end else begin
          wanted_result = expected_pixels.pop_front();
          if (seen_result != wanted_result) begin
            error_count++;
            if (error_count <= 10)
              $display("%0t: mismatch exp r=%0d g=%0d b=%0d wr=%0d, got r=%0d g=%0d b=%0d wr=%0d",
                       $realtime, wanted_result.pix.red, wanted_result.pix.green,
                       wanted_result.pix.blue, wanted_result.written,
                       out_red, out_green, out_blue, written);
          end
        end
      end
    end
  end

  // Stimulus: reset, directed cases, then random phases.
  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Register defaults: fill with black.
    queue_pixel(24'hFFFFFF, 24'h123456);
    queue_pixel(24'h000000, 24'h000000);
    wait_drained();

    // Fill; bit 8 of the red data must be dropped. The second pixel
    // already holds the paint colour and is still reported as written.
    write_register(REG_OP_MODE, DataWidth'(OP_FILL));
    write_register(REG_PAINT_RED, 9'h1FF);
    write_register(REG_PAINT_GREEN, 9'h000);
    write_register(REG_PAINT_BLUE, 9'h080);
    queue_pixel(24'h0A0B0C, 24'hFFFFFF);
    queue_pixel(24'hFF0080, 24'h000000);
    wait_drained();

    // Blend at full opacity, at zero opacity and half way.
    write_register(REG_OP_MODE, DataWidth'(OP_BLEND));
    queue_pixel(24'h000000, 24'h000000);
    wait_drained();
    write_register(REG_PAINT_ALPHA, 9'h000);
    queue_pixel(24'hFFFFFF, 24'h000000);
    queue_pixel(24'h102030, 24'hFFFFFF);
    wait_drained();
    write_register(REG_PAINT_ALPHA, 9'h080);
    queue_pixel(24'h000000, 24'h000000);
    queue_pixel(24'hFFFFFF, 24'hFFFFFF);
    queue_pixel(24'h7F80FE, 24'h010203);
    wait_drained();

    // Colour key: pure white only is transparent; an identical copy still writes.
    write_register(REG_OP_MODE, DataWidth'(OP_KEY));
    queue_pixel(24'h112233, 24'hFFFFFF);
    queue_pixel(24'h112233, 24'hFEFFFF);
    queue_pixel(24'h112233, 24'hFFFFFE);
    queue_pixel(24'hFFFFFF, 24'h000000);
    queue_pixel(24'h445566, 24'h445566);
    wait_drained();

    // Bright shift with wrap-around, and the threshold on each channel.
    write_register(REG_OP_MODE, DataWidth'(OP_SHIFT));
    write_register(REG_SHIFT_AMOUNT, ShiftPlus55);
    queue_pixel(24'hC9C9C9, 24'h000000);
    queue_pixel(24'hFFFFFF, 24'h000000);
    queue_pixel(24'hC8FFFF, 24'h000000);
    queue_pixel(24'hFFC8FF, 24'h000000);
    queue_pixel(24'hFFFFC8, 24'h000000);
    wait_drained();

    // A shift of -256 leaves the value but still writes.
    write_register(REG_SHIFT_AMOUNT, ShiftMinus256);
    queue_pixel(24'hE0E0E0, 24'h000000);
    wait_drained();
    write_register(REG_SHIFT_AMOUNT, ShiftMinus255);
    queue_pixel(24'hFAFBFC, 24'h000000);
    wait_drained();
    write_register(REG_SHIFT_AMOUNT, ShiftPlus255);
    queue_pixel(24'hCACBCC, 24'h000000);
    wait_drained();

    // Writes to unmapped indexes must change nothing.
    write_register(RegUnusedLo, 9'h1FF);
    write_register(RegUnusedHi, 9'h000);
    queue_pixel(24'hFFFFFF, 24'hFFFFFF);
    wait_drained();

    // Random phases, each with its own settings and idling style.
    while (random_jobs < 1350) begin
      phase_mode = op_mode_t'($urandom_range(0, 3));
      no_idle_run = ($urandom_range(0, 3) == 0);
      write_register(REG_OP_MODE, {7'($urandom()), phase_mode});
      if ($urandom_range(0, 1)) write_register(REG_PAINT_RED, 9'($urandom()));
      if ($urandom_range(0, 1)) write_register(REG_PAINT_GREEN, 9'($urandom()));
      if ($urandom_range(0, 1)) write_register(REG_PAINT_BLUE, 9'($urandom()));
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 5))
          0: write_register(REG_PAINT_ALPHA, 9'h000);
          1: write_register(REG_PAINT_ALPHA, 9'h001);
          2: write_register(REG_PAINT_ALPHA, 9'h0FE);
          3: write_register(REG_PAINT_ALPHA, 9'h0FF);
          default: write_register(REG_PAINT_ALPHA, 9'($urandom()));
        endcase
      end
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 5))
          0: write_register(REG_SHIFT_AMOUNT, ShiftMinus256);
          1: write_register(REG_SHIFT_AMOUNT, ShiftMinus255);
          2: write_register(REG_SHIFT_AMOUNT, ShiftPlus255);
          3: write_register(REG_SHIFT_AMOUNT, '0);
          default: write_register(REG_SHIFT_AMOUNT, 9'($urandom()));
        endcase
      end
      if ($urandom_range(0, 7) == 0)
        write_register($urandom_range(0, 1) ? RegUnusedLo : RegUnusedHi, 9'($urandom()));

      phase_len = $urandom_range(20, 80);
      repeat (phase_len) begin
        rand_dst = {rand_channel(), rand_channel(), rand_channel()};
        rand_src = {rand_channel(), rand_channel(), rand_channel()};
        if (phase_mode == OP_SHIFT && $urandom_range(0, 3) != 0)
          rand_dst = {bright_channel(), bright_channel(), bright_channel()};
        if (phase_mode == OP_KEY) begin
          case ($urandom_range(0, 9))
            0, 1, 2: rand_src = WhitePixel;
            3: begin
              rand_src = WhitePixel;
              rand_src[$urandom_range(0, 3 * ChanWidth - 1)] = 1'b0;
            end
            default: ;
          endcase
        end
        queue_pixel(rand_dst, rand_src);
        random_jobs++;
      end
      wait_drained();
    end

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
